FILE: rtl/mbf_pkg.sv
// Shared constants and register codes for the mipmap chain box filter.
// No dependencies.
`default_nettype none
package mbf_pkg;
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int LEVELS_DEF    = 11;
   localparam int SIZE_W        = 11;
   localparam int GAIN_W        = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_IDX_W     = 2;
   localparam int CHAN_W        = 8;
   localparam int PAIR_CHAN_W   = 9;
   localparam int PAIR_W        = 3 * PAIR_CHAN_W;
   localparam int POS_W         = 9;
   localparam int LVL_OUT_W     = 4;

   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BRIGHTNESS_GAIN = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
endpackage
`default_nettype wire

FILE: rtl/mbf_req_if.sv
// Source pixel channel: valid/ready with one RGB pixel per item.
// Depends on mbf_pkg.
`default_nettype none
interface mbf_req_if;
   logic                        valid;
   logic                        ready;
   logic [mbf_pkg::CHAN_W-1:0]  red_in;
   logic [mbf_pkg::CHAN_W-1:0]  green_in;
   logic [mbf_pkg::CHAN_W-1:0]  blue_in;
   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

FILE: rtl/mbf_rsp_if.sv
// Result channel: valid/ready with one filtered mipmap pixel per item.
// Depends on mbf_pkg.
`default_nettype none
interface mbf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mbf_pkg::LVL_OUT_W-1:0]  level_num;
   logic [mbf_pkg::POS_W-1:0]      pos_x;
   logic [mbf_pkg::POS_W-1:0]      pos_y;
   logic [mbf_pkg::CHAN_W-1:0]     red_out;
   logic [mbf_pkg::CHAN_W-1:0]     green_out;
   logic [mbf_pkg::CHAN_W-1:0]     blue_out;
   logic                           run_last;
   modport source (output valid, level_num, pos_x, pos_y, red_out, green_out, blue_out,
                   run_last, input ready);
   modport sink   (input valid, level_num, pos_x, pos_y, red_out, green_out, blue_out,
                   run_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/mipmap_chain_box_filter_unit.sv
// Mipmap chain box filter: cascaded 2x2 averaging with gain over all levels.
// Each accepted item passes through the level, read, multiply and finish states for
// each result. A new item is taken only in the idle state, once the chain for the last
// item is done; a held output register stalls the sequencer.
// Reset: synchronous; clears counters and holds, sizes 1024, gain 256.
// Depends on mbf_pkg, mbf_req_if, mbf_rsp_if, mbf_ram.
`default_nettype none
module mipmap_chain_box_filter_unit #(
   parameter int MAX_WIDTH = mbf_pkg::MAX_WIDTH_DEF,
   parameter int LEVELS    = mbf_pkg::LEVELS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   mbf_req_if.sink                                 req_bus,
   mbf_rsp_if.source                               rsp_bus,
   input  wire logic                               csr_we,
   input  wire logic [mbf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mbf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = AW + 1;
   localparam int RW = (CW > mbf_pkg::SIZE_W) ? CW : mbf_pkg::SIZE_W;
   localparam int LW = $clog2(LEVELS);
   localparam int PC = mbf_pkg::PAIR_CHAN_W;
   localparam int PW = mbf_pkg::PAIR_W;
   localparam int SUM_W  = PC + 1;
   localparam int PROD_W = SUM_W + mbf_pkg::GAIN_W;
   localparam int POS_W_L = mbf_pkg::POS_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_LEVEL = 5'b00010,
      S_READ  = 5'b00100,
      S_MUL   = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [mbf_pkg::SIZE_W-1:0] width_ff, height_ff;
   logic [mbf_pkg::GAIN_W-1:0] gain_ff;
   logic [AW-1:0] col_ff [LEVELS];
   logic [AW-1:0] row_ff [LEVELS];
   logic [PW-1:0] hold_ff [LEVELS];
   logic [LW-1:0] lv_ff, lv_in;
   logic [PW-1:0] pix_ff, pix_in;
   logic [PW-1:0] hs_ff;
   logic [POS_W_L-1:0] ox_ff, oy_ff;
   logic [SUM_W-1:0]  sum_ff [3];
   logic [PROD_W-1:0] prod_ff [3];
   logic pend_ff, pend_in;
   logic [mbf_pkg::LVL_OUT_W-1:0] plv_ff;
   logic [POS_W_L-1:0] px_ff, py_ff;
   logic [PW-1:0] prgb_ff;
   logic rsp_valid_ff;

   logic [RW-1:0] wr, hr;
   logic [CW-1:0] w, h, wl, hl, nx, ny, xe, ye, base;
   logic [AW-1:0] x, y;
   logic [CW:0]   idx_sum;
   logic [AW-1:0] idx;
   logic end_chain, inr, goes_read, stall, do_level, push;
   logic [PW-1:0] hs, ram_rdata, res;
   logic size_wr;

   always_comb begin
      wr = RW'(width_ff);
      hr = RW'(height_ff);
      if (wr == '0) w = CW'(1);
      else if (wr > RW'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
      else w = CW'(wr);
      if (hr == '0) h = CW'(1);
      else if (hr > RW'(MAX_WIDTH)) h = CW'(MAX_WIDTH);
      else h = CW'(hr);
      wl = w >> lv_ff;
      hl = h >> lv_ff;
      x  = col_ff[lv_ff];
      y  = row_ff[lv_ff];
      xe = {wl[CW-1:1], 1'b0};
      ye = {hl[CW-1:1], 1'b0};
      end_chain = (32'(lv_ff) == LEVELS - 1) || (wl == '0) || (hl == '0);
      inr = ({1'b0, x} < xe) && ({1'b0, y} < ye);
      goes_read = !end_chain && inr && x[0] && y[0];
      stall = pend_ff && rsp_valid_ff && !rsp_bus.ready;
      do_level = (state_ff == S_LEVEL) && !stall;
      push = do_level && pend_ff;
      nx = CW'(x) + CW'(1);
      ny = CW'(y);
      if (nx >= wl) begin
         nx = '0;
         ny = CW'(y) + CW'(1);
         if (ny >= hl) ny = '0;
      end
      for (int c = 0; c < 3; c++) begin
         hs[c*PC +: PC] = hold_ff[lv_ff][c*PC +: PC] + pix_ff[c*PC +: PC];
      end
      base = CW'(MAX_WIDTH) - (CW'(MAX_WIDTH) >> lv_ff);
      idx_sum = (CW+1)'(base) + (CW+1)'(x >> 1);
      idx = (idx_sum >= (CW+1)'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : idx_sum[AW-1:0];
      for (int c = 0; c < 3; c++) begin
         logic [PROD_W:0] r;
         r = (PROD_W+1)'(prod_ff[c]) + (PROD_W+1)'(512);
         res[c*PC +: PC] = (r[PROD_W:10] > (PROD_W-9)'(255)) ? PC'(255)
                                                              : PC'(r[PROD_W:10]);
      end
      size_wr = csr_we && ((csr_index == mbf_pkg::REG_SOURCE_WIDTH) ||
                           (csr_index == mbf_pkg::REG_SOURCE_HEIGHT));
   end

   always_comb begin
      state_in = state_ff;
      lv_in    = lv_ff;
      pix_in   = pix_ff;
      pend_in  = pend_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               pix_in = {1'b0, req_bus.blue_in, 1'b0, req_bus.green_in, 1'b0, req_bus.red_in};
               lv_in = '0;
               state_in = S_LEVEL;
            end
         end
         S_LEVEL: begin
            if (!stall) begin
               pend_in = 1'b0;
               state_in = goes_read ? S_READ : S_IDLE;
            end
         end
         S_READ: state_in = S_MUL;
         S_MUL:  state_in = S_FIN;
         S_FIN: begin
            pix_in = res;
            pend_in = 1'b1;
            lv_in = lv_ff + LW'(1);
            state_in = S_LEVEL;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_bus.ready = (state_ff == S_IDLE);

   mbf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row_ram (
      .clock (clock),
      .we    (do_level && !end_chain && inr && x[0] && !y[0]),
      .waddr (idx),
      .wdata (hs),
      .re    (do_level && goes_read),
      .raddr (idx),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lv_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff <= mbf_pkg::SIZE_RESET;
         height_ff <= mbf_pkg::SIZE_RESET;
         gain_ff <= mbf_pkg::GAIN_RESET;
         for (int i = 0; i < LEVELS; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
            hold_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         lv_ff <= lv_in;
         pend_ff <= pend_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we && csr_index == mbf_pkg::REG_SOURCE_WIDTH) begin
            width_ff <= csr_wdata[mbf_pkg::SIZE_W-1:0];
         end
         if (csr_we && csr_index == mbf_pkg::REG_SOURCE_HEIGHT) begin
            height_ff <= csr_wdata[mbf_pkg::SIZE_W-1:0];
         end
         if (csr_we && csr_index == mbf_pkg::REG_BRIGHTNESS_GAIN) begin
            gain_ff <= csr_wdata[mbf_pkg::GAIN_W-1:0];
         end
         if (size_wr) begin
            for (int i = 0; i < LEVELS; i++) begin
               col_ff[i] <= '0;
               row_ff[i] <= '0;
               hold_ff[i] <= '0;
            end
         end else if (do_level && !end_chain) begin
            col_ff[lv_ff] <= AW'(nx);
            row_ff[lv_ff] <= AW'(ny);
            if (inr && !x[0]) hold_ff[lv_ff] <= pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      if (do_level) begin
         hs_ff <= hs;
         ox_ff <= POS_W_L'(x >> 1);
         oy_ff <= POS_W_L'(y >> 1);
      end
      if (state_ff == S_READ) begin
         for (int c = 0; c < 3; c++) begin
            sum_ff[c] <= SUM_W'(ram_rdata[c*PC +: PC]) + SUM_W'(hs_ff[c*PC +: PC]);
         end
      end
      if (state_ff == S_MUL) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[c] <= PROD_W'(sum_ff[c]) * PROD_W'(gain_ff);
         end
      end
      if (state_ff == S_FIN) begin
         plv_ff <= mbf_pkg::LVL_OUT_W'(32'(lv_ff) + 1);
         px_ff <= ox_ff;
         py_ff <= oy_ff;
         prgb_ff <= res;
      end
      if (push) begin
         rsp_bus.level_num <= plv_ff;
         rsp_bus.pos_x <= px_ff;
         rsp_bus.pos_y <= py_ff;
         rsp_bus.red_out <= prgb_ff[mbf_pkg::CHAN_W-1:0];
         rsp_bus.green_out <= prgb_ff[PC +: mbf_pkg::CHAN_W];
         rsp_bus.blue_out <= prgb_ff[2*PC +: mbf_pkg::CHAN_W];
         rsp_bus.run_last <= !goes_read;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_read_then_sum: assert property (@(posedge clock) disable iff (reset)
      (do_level && goes_read) |=> (state_ff == S_READ))
      else $error("row store read not followed by sum");
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_ff)
      else $error("pending result left behind at idle");
   a_fin_sets_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |=> (pend_ff && state_ff == S_LEVEL))
      else $error("filtered result not held for output");
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (32'(lv_ff) <= LEVELS - 1))
      else $error("level index out of range");
`endif
endmodule
`default_nettype wire

FILE: rtl/mbf_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none
module mbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire
